[design/utc_pkg.sv]
`timescale 1ns / 1ps
// utc_pkg: shared types and constants of the utf8 text classifier
// no dependencies; imported by every module of the block
package utc_pkg;

    // longest string in bytes before the too_long verdict
    localparam int MAX_LEN = 65535;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    // running 10*latin - 9*content lies in [-9*MAX_LEN, MAX_LEN]
    localparam int DIFF_W  = $clog2(9 * MAX_LEN + 1) + 1;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    // byte codes
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CODE_CONT  = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;

    // latin weighting: latin*10 >= content*9
    localparam logic signed [DIFF_W-1:0] DIFF_LATIN = DIFF_W'(1);
    localparam logic signed [DIFF_W-1:0] DIFF_OTHER = -DIFF_W'(9);

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic too_long;
        logic mostly_latin;
        logic printable;
        logic valid_utf8;
    } verdict_t;

endpackage

[design/utc_in_stage.sv]
`timescale 1ns / 1ps
// utc_in_stage: input register of the classifier, one item deep
// uses utc_pkg item type
module utc_in_stage
    import utc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  pop,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

[design/utc_tracker.sv]
`timescale 1ns / 1ps
// utc_tracker: per-string state and the verdict logic of the classifier
// uses utc_pkg constants and types
module utc_tracker
    import utc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  item_t    item,
    output verdict_t verdict,
    output logic     idle_state
);

    logic [1:0]               pend_reg, pend_next;
    logic                     bad_reg, bad_next;
    logic                     ctrl_reg, ctrl_next;
    logic                     ovf_reg, ovf_next;
    logic                     nz_reg, nz_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;

    logic [7:0] b;
    logic       is_cont;
    logic       is_control;
    logic       is_content;
    logic       is_latin;
    logic       ok;

    assign b          = item.byte_value;
    assign is_cont    = (b & MASK_CONT) == CODE_CONT;
    assign is_control = (b < BYTE_SPACE && b != BYTE_TAB) || b == BYTE_DEL;
    assign is_content = b != BYTE_SPACE && b != BYTE_TAB;
    assign is_latin   = !is_cont;

    // state after this item, before the end-of-string clear
    always_comb
    begin
        pend_next = pend_reg;
        bad_next  = bad_reg;
        ctrl_next = ctrl_reg;
        ovf_next  = ovf_reg;
        nz_next   = nz_reg;
        cnt_next  = cnt_reg;
        diff_next = diff_reg;
        if (item.has_byte)
        begin
            if (cnt_reg >= MAX_CNT)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (pend_reg != 2'd0)
                begin
                    if (is_cont)
                    begin
                        pend_next = pend_reg - 2'd1;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                else
                begin
                    priority if (!b[7])
                    begin
                        pend_next = 2'd0;
                    end
                    else if ((b & MASK_LEAD2) == CODE_LEAD2)
                    begin
                        pend_next = 2'd1;
                    end
                    else if ((b & MASK_LEAD3) == CODE_LEAD3)
                    begin
                        pend_next = 2'd2;
                    end
                    else if ((b & MASK_LEAD4) == CODE_LEAD4)
                    begin
                        pend_next = 2'd3;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                if (is_control)
                begin
                    ctrl_next = 1'b1;
                end
                if (is_content)
                begin
                    nz_next   = 1'b1;
                    diff_next = diff_reg + (is_latin ? DIFF_LATIN : DIFF_OTHER);
                end
            end
        end
    end

    assign ok = !bad_next && pend_next == 2'd0 && !ovf_next;

    assign verdict.valid_utf8   = ok;
    assign verdict.printable    = ok && cnt_next != '0 && !ctrl_next;
    assign verdict.mostly_latin = ok && nz_next && !diff_next[DIFF_W-1];
    assign verdict.too_long     = ovf_next;

    assign idle_state = pend_reg == 2'd0 && !bad_reg && !ctrl_reg && !ovf_reg
                        && !nz_reg && cnt_reg == '0 && diff_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            bad_reg  <= 1'b0;
            ctrl_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            nz_reg   <= 1'b0;
            cnt_reg  <= '0;
            diff_reg <= '0;
        end
        else if (step)
        begin
            if (item.last)
            begin
                // string ends: start clean
                pend_reg <= 2'd0;
                bad_reg  <= 1'b0;
                ctrl_reg <= 1'b0;
                ovf_reg  <= 1'b0;
                nz_reg   <= 1'b0;
                cnt_reg  <= '0;
                diff_reg <= '0;
            end
            else
            begin
                pend_reg <= pend_next;
                bad_reg  <= bad_next;
                ctrl_reg <= ctrl_next;
                ovf_reg  <= ovf_next;
                nz_reg   <= nz_next;
                cnt_reg  <= cnt_next;
                diff_reg <= diff_next;
            end
        end
    end

endmodule

[design/utc_out_stage.sv]
`timescale 1ns / 1ps
// utc_out_stage: result register of the classifier, one item deep
// uses utc_pkg verdict type
module utc_out_stage
    import utc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  verdict_t verdict_in,
    output logic     slot_free,
    output logic     m_valid,
    input  logic     m_ready,
    output verdict_t verdict_out
);

    logic     valid_reg;
    logic     valid_next;
    verdict_t verdict_reg;

    assign slot_free   = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign verdict_out = verdict_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict_in;
        end
    end

endmodule

[design/utf8_text_classifier_top.sv]
`timescale 1ns / 1ps
// utf8_text_classifier_top: top level of the utf8 text classifier
// uses utc_pkg, utc_in_stage, utc_tracker, utc_out_stage

// Streams a string in one byte per item and, on the item marked tlast, returns one
// item of four flags: lax utf-8 well formed, printable, mostly latin and too long.
// A byte is carried in s_axis_tdata with s_axis_tuser high; an item with
// s_axis_tuser low carries no byte and, with tlast, marks an empty string or just
// ends the string. Items without tlast give no result. The block takes one item
// every cycle: an input register feeds the per-string state update, whose
// verdict lands in a result register, and the input keeps flowing while a result
// waits, unless a second result would overwrite an untaken one. Strings longer than
// MAX_LEN bytes (utc_pkg) report too_long with all other flags low.
module utf8_text_classifier_top
    import utc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
    input  logic       s_axis_tuser,   // [0] has_byte
    input  logic       s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] valid_utf8, [1] printable,
                                       // [2] mostly_latin, [3] too_long, [7:4] zero
);

    item_t    s_item;
    item_t    item;
    logic     item_valid;
    logic     slot_free;
    logic     step;
    logic     idle_state;
    verdict_t verdict;
    verdict_t verdict_out;

    assign s_item.byte_value = s_axis_tdata;
    assign s_item.has_byte   = s_axis_tuser;
    assign s_item.last       = s_axis_tlast;

    // an item moves on unless it ends a string and the result slot is taken
    assign step = item_valid && (!item.last || slot_free);

    utc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .pop        (step),
        .item_valid (item_valid),
        .item       (item)
    );

    utc_tracker u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item),
        .verdict    (verdict),
        .idle_state (idle_state)
    );

    // results only on the end-of-string item
    utc_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && item.last),
        .verdict_in  (verdict),
        .slot_free   (slot_free),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .verdict_out (verdict_out)
    );

    assign m_axis_tdata = {4'b0000, verdict_out};

    // too_long forces the other verdicts low
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == 3'b000)
        else $error("too_long result with a verdict set");

    // printable and mostly latin both need a well formed string
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1] || m_axis_tdata[2]) |-> m_axis_tdata[0])
        else $error("verdict set on malformed string");

    // state starts clean after an end-of-string item
    assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last |=> idle_state)
        else $error("string state not cleared");

    // an empty input register always accepts
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> s_axis_tready)
        else $error("input stalled while empty");

endmodule

[tb/sv/utf8_text_classifier_top_test.sv]
`timescale 1ns / 1ps
// utf8_text_classifier_top_test: self-checking bench for the utf8 text classifier
// depends on utc_pkg and utf8_text_classifier_top with its submodules

module utf8_text_classifier_top_test
    import utc_pkg::*;
();

    // no-acceptance cycles before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;
    // length of the forced receiver hold-off, in cycles
    localparam int HOLD_LEN       = 300;
    // random part size, and how much of it runs without any idling
    localparam int RANDOM_ITEMS   = 1150;
    localparam int CALM_ITEMS     = 300;
    // cycles to wait after the last result before deciding
    localparam int DRAIN_CYCLES   = 10;

    // dut ports, all inputs known from time zero
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tuser  = 1'b0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    // bench control
    bit         idle_on   = 1'b0;     // random gaps on both sides
    bit         noise_on  = 1'b0;     // ignored no-byte items inside strings
    bit         hold_req  = 1'b0;     // ask the receiver for one long hold-off
    int         errors    = 0;
    int         items_sent = 0;       // items that update the classifier
    int         quiet_cycles = 0;

    // expected verdicts, oldest first
    verdict_t   verdict_q[$];
    verdict_t   want;

    // bytes of the next string to send
    logic [7:0] text_buf[$];

    // predictor state for the string in flight
    logic [1:0]       cont_left;
    logic             seq_error;
    logic             ctrl_seen;
    logic             overflow;
    logic [CNT_W-1:0] byte_cnt;
    logic [CNT_W-1:0] content_cnt;
    logic [CNT_W-1:0] latin_cnt;

    utf8_text_classifier_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    //------------------------------------------------------------------
    // verdict predictor
    //------------------------------------------------------------------

    // clear the per-string state, as after reset and after each verdict
    function automatic void clear_string();
        cont_left   = 2'd0;
        seq_error   = 1'b0;
        ctrl_seen   = 1'b0;
        overflow    = 1'b0;
        byte_cnt    = '0;
        content_cnt = '0;
        latin_cnt   = '0;
    endfunction

    // fold one accepted item into the string state; queue a verdict on last
    function automatic void classify_item(logic [7:0] b, logic has, logic lst);
        verdict_t v;
        if (has)
        begin
            if (byte_cnt >= MAX_CNT)
                overflow = 1'b1;        // past the limit: byte only marks too long
            else
            begin
                byte_cnt = byte_cnt + CNT_W'(1);
                // structure: a pending sequence eats the byte, lead or not
                if (cont_left != 2'd0)
                begin
                    if ((b & MASK_CONT) == CODE_CONT)
                        cont_left = cont_left - 2'd1;
                    else
                        seq_error = 1'b1;
                end
                else if (!b[7])
                    ;                   // plain ascii
                else if ((b & MASK_LEAD2) == CODE_LEAD2)
                    cont_left = 2'd1;
                else if ((b & MASK_LEAD3) == CODE_LEAD3)
                    cont_left = 2'd2;
                else if ((b & MASK_LEAD4) == CODE_LEAD4)
                    cont_left = 2'd3;
                else
                    seq_error = 1'b1;   // stray continuation or f8-ff
                if ((b < BYTE_SPACE && b != BYTE_TAB) || b == BYTE_DEL)
                    ctrl_seen = 1'b1;
                // blanks are not content; continuation bytes are not latin
                if (b != BYTE_SPACE && b != BYTE_TAB)
                begin
                    content_cnt = content_cnt + CNT_W'(1);
                    if ((b & MASK_CONT) != CODE_CONT)
                        latin_cnt = latin_cnt + CNT_W'(1);
                end
            end
        end
        if (lst)
        begin
            v.valid_utf8   = !seq_error && cont_left == 2'd0 && !overflow;
            v.printable    = v.valid_utf8 && byte_cnt != '0 && !ctrl_seen;
            v.mostly_latin = v.valid_utf8 && content_cnt != '0 &&
                             longint'(latin_cnt) * 100 >= longint'(content_cnt) * 90;
            v.too_long     = overflow;
            verdict_q.insert(verdict_q.size(), v);
            clear_string();
        end
    endfunction

    //------------------------------------------------------------------
    // sender
    //------------------------------------------------------------------

    // append one byte to the string being built
    function automatic void add_byte(logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    // offer one item, called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic has, input logic lst);
        while (idle_on && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= has;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        classify_item(b, has, lst);
        if (has || lst)
            items_sent++;
        @(negedge clk);
    endtask

    // send text_buf as one string; close it with a no-byte item if asked or empty
    task automatic send_text(input bit end_marker);
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
        begin
            // a no-byte item without last is ignored by the block
            if (noise_on && $urandom_range(99) < 5)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(text_buf[i], 1'b1, !end_marker && i == n - 1);
        end
        if (end_marker || n == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
        text_buf.delete();
    endtask

    // append one well formed character of a random class
    function automatic void add_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            add_byte(8'($urandom_range(8'h21, 8'h7E)));
        else if (pick < 48)
            add_byte($urandom_range(1) ? BYTE_SPACE : BYTE_TAB);
        else if (pick < 53)
            add_byte($urandom_range(3) == 0 ? BYTE_DEL : 8'($urandom_range(8'h1F)));
        else if (pick < 73)
        begin
            add_byte(CODE_LEAD2 | 8'($urandom_range(31)));
            add_byte(CODE_CONT | 8'($urandom_range(63)));
        end
        else if (pick < 88)
        begin
            add_byte(CODE_LEAD3 | 8'($urandom_range(15)));
            repeat (2) add_byte(CODE_CONT | 8'($urandom_range(63)));
        end
        else
        begin
            add_byte(CODE_LEAD4 | 8'($urandom_range(7)));
            repeat (3) add_byte(CODE_CONT | 8'($urandom_range(63)));
        end
    endfunction

    //------------------------------------------------------------------
    // receiver: random ready, with one long hold-off on request
    //------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                for (int k = 0; k < HOLD_LEN; k++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= !idle_on || $urandom_range(99) >= 30;
        end
    end

    //------------------------------------------------------------------
    // result checker
    //------------------------------------------------------------------

    task automatic check_flag(input string name, input logic exp_v, input logic act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_flag("valid_utf8",   want.valid_utf8,   m_axis_tdata[0]);
                check_flag("printable",    want.printable,    m_axis_tdata[1]);
                check_flag("mostly_latin", want.mostly_latin, m_axis_tdata[2]);
                check_flag("too_long",     want.too_long,     m_axis_tdata[3]);
                if (m_axis_tdata[7:4] !== 4'h0)
                begin
                    $display("%0t: pad bits mismatch, expected 0 actual %h",
                             $time, m_axis_tdata[7:4]);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    //------------------------------------------------------------------
    // tests
    //------------------------------------------------------------------

    // empty string, ignored no-byte item, no-byte item closing a string
    task automatic test_empty_and_markers();
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
    endtask

    // one-byte strings over the byte classes and the range extremes
    task automatic test_single_bytes();
        logic [7:0] picks[8];
        picks = '{8'h00, BYTE_TAB, BYTE_SPACE, BYTE_DEL, 8'h41, 8'hFF, CODE_CONT, 8'hF8};
        foreach (picks[i])
            send_item(picks[i], 1'b1, 1'b1);
    endtask

    // 2, 3 and 4 byte sequences, a cut-off one and a broken one
    task automatic test_multibyte();
        text_buf = '{8'hC3, 8'hA9};               send_text(1'b0);
        text_buf = '{8'hE2, 8'h82, 8'hAC};        send_text(1'b0);
        text_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80}; send_text(1'b0);
        text_buf = '{8'hE2, 8'h82};               send_text(1'b0);
        // non-continuation where one is due, not taken as a new lead
        text_buf = '{8'hC3, 8'h41};               send_text(1'b0);
    endtask

    // latin share exactly at 90 percent, then just below it
    task automatic test_latin_threshold();
        repeat (8) add_byte(8'h61);
        add_byte(8'hC3);
        add_byte(8'hA9);
        send_text(1'b0);
        repeat (7) add_byte(8'h61);
        add_byte(8'hC3);
        add_byte(8'hA9);
        send_text(1'b1);
    endtask

    // receiver holds off while short strings keep coming, so the input backs up
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++)
            send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b1, 1'b1);
    endtask

    // random strings: mostly well formed, some broken by a stray byte or a cut
    task automatic test_random_text();
        int target;
        int chars;
        int pos;
        target = items_sent + RANDOM_ITEMS;
        noise_on = 1'b1;
        while (items_sent < target)
        begin
            // first stretch runs without idling
            idle_on = items_sent >= target - RANDOM_ITEMS + CALM_ITEMS;
            chars = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 10);
            for (int c = 0; c < chars; c++)
                add_char();
            if ($urandom_range(99) < 20 && text_buf.size() > 0)
            begin
                case ($urandom_range(2))
                    0: text_buf.delete(text_buf.size() - 1);
                    1:
                    begin
                        pos = $urandom_range(text_buf.size());
                        text_buf.insert(pos, 8'($urandom_range(8'h80, 8'hFF)));
                    end
                    default:
                    begin
                        pos = $urandom_range(text_buf.size());
                        text_buf.insert(pos, 8'($urandom));
                    end
                endcase
            end
            send_text($urandom_range(4) == 0);
        end
        noise_on = 1'b0;
    endtask

    //------------------------------------------------------------------
    // main sequence
    //------------------------------------------------------------------
    initial
    begin
        clear_string();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_on = 1'b1;
        test_empty_and_markers();
        test_single_bytes();
        test_multibyte();
        test_latin_threshold();
        test_backpressure();
        test_random_text();

        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
